// ===== design/sync_length_frame_receiver_assert.svh =====
// ----------------------------------------------------------------------------
// sync_length_frame_receiver_assert.svh
// Assertion macros shared by the frame receiver modules.
// ----------------------------------------------------------------------------
`ifndef SYNC_LENGTH_FRAME_RECEIVER_ASSERT_SVH
`define SYNC_LENGTH_FRAME_RECEIVER_ASSERT_SVH

// Check that a condition holds at every clock edge outside reset.
`define SLFR_ASSERT_ALWAYS(name, clk, rst, cond, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a consequence holds in the same cycle as its trigger.
`define SLFR_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that a consequence holds in the cycle after its trigger.
`define SLFR_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/slfr_pkg.sv =====
// ----------------------------------------------------------------------------
// slfr_pkg
// Types and constants of the sync-word, length-prefixed frame receiver.
// ----------------------------------------------------------------------------
package slfr_pkg;

   // sync word "ANSI"
   localparam logic [7:0] SYNC_0 = 8'h41;
   localparam logic [7:0] SYNC_1 = 8'h4E;
   localparam logic [7:0] SYNC_2 = 8'h53;
   localparam logic [7:0] SYNC_3 = 8'h49;

   localparam int unsigned CSR_ADDR_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH = 32;
   localparam logic        CSR_IDX_MAX_LENGTH = 1'b0;
   localparam logic [15:0] MAX_LENGTH_RESET = 16'd256;

   typedef enum logic [2:0] {
      PH_SYNC0   = 3'd0,
      PH_SYNC1   = 3'd1,
      PH_SYNC2   = 3'd2,
      PH_SYNC3   = 3'd3,
      PH_TYPE    = 3'd4,
      PH_LEN_LO  = 3'd5,
      PH_LEN_HI  = 3'd6,
      PH_PAYLOAD = 3'd7
   } phase_type;

   // one classified item waiting for the output side
   typedef struct packed {
      logic [7:0]  frame_type;
      logic [7:0]  data_byte;
      logic [15:0] byte_index;
      logic        last_byte;
      logic        empty_frame;
      logic [15:0] length;
   } queue_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// ===== design/slfr_front.sv =====
// ----------------------------------------------------------------------------
// slfr_front
// Byte parser: tracks sync, type and length, pushes payload and empty-frame
// items into the queue.
// ----------------------------------------------------------------------------
`include "sync_length_frame_receiver_assert.svh"

module slfr_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  logic [7:0]               rx_byte,
   output logic                     push,
   output slfr_pkg::queue_entry_type push_entry
);
   import slfr_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [7:0]  type_ff, type_in;
   logic [15:0] length_ff, length_in;
   logic [15:0] count_ff, count_in;
   logic [15:0] full_length;
   logic        last;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_SYNC0;
         type_ff   <= '0;
         length_ff <= '0;
         count_ff  <= '0;
      end else begin
         phase_ff  <= phase_in;
         type_ff   <= type_in;
         length_ff <= length_in;
         count_ff  <= count_in;
      end
   end

   assign full_length = {rx_byte, length_ff[7:0]};
   assign last = ({1'b0, count_ff} + 17'd1) >= {1'b0, length_ff};

   always_comb begin
      phase_in   = phase_ff;
      type_in    = type_ff;
      length_in  = length_ff;
      count_in   = count_ff;
      push       = 1'b0;
      push_entry = '{frame_type: type_ff, data_byte: rx_byte, byte_index: count_ff,
                     last_byte: last, empty_frame: 1'b0, length: length_ff};
      if (accept) begin
         case (phase_ff)
            PH_SYNC0: phase_in = (rx_byte == SYNC_0) ? PH_SYNC1 : PH_SYNC0;
            PH_SYNC1: phase_in = (rx_byte == SYNC_1) ? PH_SYNC2 : PH_SYNC0;
            PH_SYNC2: phase_in = (rx_byte == SYNC_2) ? PH_SYNC3 : PH_SYNC0;
            PH_SYNC3: phase_in = (rx_byte == SYNC_3) ? PH_TYPE  : PH_SYNC0;
            PH_TYPE: begin
               type_in  = rx_byte;
               phase_in = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               length_in = {8'h00, rx_byte};
               phase_in  = PH_LEN_HI;
            end
            PH_LEN_HI: begin
               length_in = full_length;
               count_in  = '0;
               if (full_length == 16'd0) begin
                  // zero-length frame: emit a single empty marker
                  push       = 1'b1;
                  push_entry = '{frame_type: type_ff, data_byte: 8'h00, byte_index: 16'd0,
                                 last_byte: 1'b1, empty_frame: 1'b1, length: 16'd0};
                  phase_in   = PH_SYNC0;
               end else begin
                  phase_in = PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               push     = 1'b1;
               count_in = count_ff + 16'd1;
               if (last) begin
                  phase_in = PH_SYNC0;
               end
            end
            default: phase_in = PH_SYNC0;
         endcase
      end
   end

   `SLFR_ASSERT_IMPL(a_count_in_frame, clock, reset, phase_ff == PH_PAYLOAD,
      count_ff < length_ff, "payload index ran past the declared length")
   `SLFR_ASSERT_IMPL(a_push_on_accept, clock, reset, push, accept,
      "item pushed without an accepted byte")
   `SLFR_ASSERT_NEXT(a_last_ends_frame, clock, reset,
      push && push_entry.last_byte, phase_ff == PH_SYNC0,
      "frame end did not restart the sync search")

endmodule

// ===== design/slfr_queue.sv =====
// ----------------------------------------------------------------------------
// slfr_queue
// Short FIFO between the parser and the output stage.
// ----------------------------------------------------------------------------
`include "sync_length_frame_receiver_assert.svh"

module slfr_queue #(
   parameter int unsigned DEPTH = 4   // at least 2
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  slfr_pkg::queue_entry_type push_entry,
   input  logic                      pop,
   output slfr_pkg::queue_entry_type head_entry,
   output slfr_pkg::queue_status_type status
);
   import slfr_pkg::*;

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   queue_entry_type  entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] ptr);
      return (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
   endfunction

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   assign head_entry   = entries_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);

   `SLFR_ASSERT_IMPL(a_no_push_full, clock, reset, push, !status.full,
      "push into a full queue")
   `SLFR_ASSERT_IMPL(a_no_pop_empty, clock, reset, pop, !status.empty,
      "pop from an empty queue")
   `SLFR_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CNT_W'(DEPTH),
      "queue count beyond depth")

endmodule

// ===== design/slfr_back.sv =====
// ----------------------------------------------------------------------------
// slfr_back
// Output stage: drains the queue, applies the oversize check, holds the
// result until it is taken.
// ----------------------------------------------------------------------------
`include "sync_length_frame_receiver_assert.svh"

module slfr_back (
   input  logic                       clock,
   input  logic                       reset,
   input  slfr_pkg::queue_entry_type  head_entry,
   input  slfr_pkg::queue_status_type status,
   input  logic [15:0]                max_length,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [7:0]                 rsp_frame_type,
   output logic [7:0]                 rsp_data_byte,
   output logic [15:0]                rsp_byte_index,
   output logic                       rsp_last_byte,
   output logic                       rsp_empty_frame,
   output logic                       rsp_oversize
);
   import slfr_pkg::*;

   logic        valid_ff, valid_in;
   logic [7:0]  frame_type_ff;
   logic [7:0]  data_byte_ff;
   logic [15:0] byte_index_ff;
   logic        last_byte_ff;
   logic        empty_frame_ff;
   logic        oversize_ff;

   // refill the output register when it is free or being taken
   assign pop = !status.empty && (!valid_ff || !rsp_stall);

   always_comb begin
      if (pop) begin
         valid_in = 1'b1;
      end else begin
         valid_in = valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         frame_type_ff  <= head_entry.frame_type;
         data_byte_ff   <= head_entry.data_byte;
         byte_index_ff  <= head_entry.byte_index;
         last_byte_ff   <= head_entry.last_byte;
         empty_frame_ff <= head_entry.empty_frame;
         oversize_ff    <= !head_entry.empty_frame && (head_entry.length > max_length);
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_frame_type  = frame_type_ff;
   assign rsp_data_byte   = data_byte_ff;
   assign rsp_byte_index  = byte_index_ff;
   assign rsp_last_byte   = last_byte_ff;
   assign rsp_empty_frame = empty_frame_ff;
   assign rsp_oversize    = oversize_ff;

   `SLFR_ASSERT_IMPL(a_empty_shape, clock, reset, valid_ff && empty_frame_ff,
      last_byte_ff && !oversize_ff && (byte_index_ff == 16'd0) && (data_byte_ff == 8'h00),
      "empty-frame result with payload fields set")
   `SLFR_ASSERT_NEXT(a_held_on_stall, clock, reset, valid_ff && rsp_stall,
      valid_ff && $stable(byte_index_ff) && $stable(data_byte_ff),
      "stalled result changed")

endmodule

// ===== design/sync_length_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// sync_length_frame_receiver
// Recovers "ANSI"-synced, type- and length-prefixed frames from a byte
// stream and emits one result per payload byte (or one per empty frame).
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake             payload
//   req_     in         req_valid/req_stall   req_rx_byte
//   rsp_     out        rsp_valid/rsp_stall   frame_type, data_byte, byte_index,
//                                             last_byte, empty_frame, oversize
//   csr      in/out     psel/penable/pready   max_length at byte address 0
//
// One byte is taken every cycle while req_stall is low; header bytes make no result.
// An accepted payload byte reaches rsp_ through a two-register path (parser
// into queue, queue into output register); rsp_stall can hold it back.
// req_stall rises only when the QUEUE_DEPTH-entry queue is full, which
// happens after rsp_stall has held the output for that many items.
// Synchronous reset returns the parser to the sync search, empties the
// queue and drops any pending result; max_length returns to 256.
// ----------------------------------------------------------------------------
module sync_length_frame_receiver #(
   parameter int unsigned QUEUE_DEPTH = 4   // parser-to-output queue, at least 2
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // byte input
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [7:0]                            req_rx_byte,
   // results
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [7:0]                            rsp_frame_type,
   output logic [7:0]                            rsp_data_byte,
   output logic [15:0]                           rsp_byte_index,
   output logic                                  rsp_last_byte,
   output logic                                  rsp_empty_frame,
   output logic                                  rsp_oversize,
   // configuration
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [slfr_pkg::CSR_ADDR_WIDTH-1:0]   paddr,
   input  logic [slfr_pkg::CSR_DATA_WIDTH-1:0]   pwdata,
   output logic [slfr_pkg::CSR_DATA_WIDTH-1:0]   prdata,
   output logic                                  pready
);
   import slfr_pkg::*;

   logic             accept;
   logic             push;
   logic             pop;
   queue_entry_type  push_entry;
   queue_entry_type  head_entry;
   queue_status_type status;

   logic [15:0] max_length_ff, max_length_in;
   logic        csr_write;
   logic        csr_hit;

   // ---- configuration register -----------------------------------------
   // word index is the top address bit; anything past the list is ignored
   assign pready    = 1'b1;
   assign csr_hit   = (paddr[CSR_ADDR_WIDTH-1] == CSR_IDX_MAX_LENGTH);
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      max_length_in = max_length_ff;
      if (csr_write && csr_hit) begin
         max_length_in = pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_length_ff <= MAX_LENGTH_RESET;
      end else begin
         max_length_ff <= max_length_in;
      end
   end

   // read back: zero outside the register list
   always_comb begin
      prdata = '0;
      if (csr_hit) begin
         prdata = {{(CSR_DATA_WIDTH - 16){1'b0}}, max_length_ff};
      end
   end

   // ---- input side: hold bytes while the queue is full ---------------------
   assign req_stall = status.full;
   assign accept    = req_valid && !req_stall;

   slfr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .rx_byte    (req_rx_byte),
      .push       (push),
      .push_entry (push_entry)
   );

   slfr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .status     (status)
   );

   // ---- output side: oversize check and result register --------------------
   slfr_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_entry      (head_entry),
      .status          (status),
      .max_length      (max_length_ff),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_frame_type  (rsp_frame_type),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_byte_index  (rsp_byte_index),
      .rsp_last_byte   (rsp_last_byte),
      .rsp_empty_frame (rsp_empty_frame),
      .rsp_oversize    (rsp_oversize)
   );

endmodule
